@@ sv/rrtt_pkg.sv @@
// Package for the round-robin task table.
// Holds table sizing, field widths, command/status codes and the
// controller/datapath interface types. No dependencies.
package rrtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W = 3;
  localparam int REF_W = 32;
  localparam int ID_W = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int LIVE_W = 5;

  localparam int IN_DATA_W = 2 * REF_W;
  localparam int OUT_FIELDS_W = STATUS_W + SLOT_FIELD_W + ID_W + 2 * REF_W + LIVE_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;
  localparam int LIVE_LSB = STATUS_W + SLOT_FIELD_W + ID_W + 2 * REF_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_FORK   = 3'd1,
    CMD_EXIT   = 3'd2,
    CMD_SCHED  = 3'd3,
    CMD_FINISH = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NO_RUN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_ADD,
    DP_RD_CUR,
    DP_FORK,
    DP_RD_LAST,
    DP_EXIT,
    DP_SCAN_FIRST,
    DP_SCAN_NEXT,
    DP_RD_SCAN,
    DP_SCHED_HIT,
    DP_FINISH,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             cur_is_last;
    logic             scan_free;
    logic             scan_at_start;
    logic             out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]    pad;
    logic [LIVE_W-1:0]       live_count;
    logic [REF_W-1:0]        run_entry_ref;
    logic [REF_W-1:0]        run_name_ref;
    logic [ID_W-1:0]         task_id;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [STATUS_W-1:0]     status;
  } out_word_t;

endpackage

@@ sv/rrtt_ctrl.sv @@
// Controller for the round-robin task table.
// Sequences each command into datapath operations. Depends on rrtt_pkg.
module rrtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rrtt_pkg::dp_stat_t stat,
  output rrtt_pkg::dp_ctrl_t ctl
);
  import rrtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FORK_WR,
    S_EXIT,
    S_SCAN,
    S_SCHED_HIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ctl.op         = DP_NOP;
    ctl.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.op    = DP_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_ADD: begin
            if (!stat.out_busy) begin
              if (stat.full) begin
                ctl.op         = DP_RESULT;
                ctl.res_status = ST_FULL;
              end else begin
                ctl.op = DP_ADD;
              end
              state_nxt = S_IDLE;
            end
          end
          CMD_FORK: begin
            if (stat.full || stat.empty) begin
              if (!stat.out_busy) begin
                ctl.op         = DP_RESULT;
                ctl.res_status = stat.full ? ST_FULL : ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctl.op    = DP_RD_CUR;
              state_nxt = S_FORK_WR;
            end
          end
          CMD_EXIT: begin
            if (stat.empty) begin
              if (!stat.out_busy) begin
                ctl.op         = DP_RESULT;
                ctl.res_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else if (stat.cur_is_last) begin
              if (!stat.out_busy) begin
                ctl.op    = DP_EXIT;
                state_nxt = S_IDLE;
              end
            end else begin
              ctl.op    = DP_RD_LAST;
              state_nxt = S_EXIT;
            end
          end
          CMD_SCHED: begin
            if (stat.empty) begin
              if (!stat.out_busy) begin
                ctl.op         = DP_RESULT;
                ctl.res_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctl.op    = DP_SCAN_FIRST;
              state_nxt = S_SCAN;
            end
          end
          CMD_FINISH: begin
            if (!stat.out_busy) begin
              if (stat.empty) begin
                ctl.op         = DP_RESULT;
                ctl.res_status = ST_EMPTY;
              end else begin
                ctl.op = DP_FINISH;
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (!stat.out_busy) begin
              ctl.op    = DP_RESULT;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_FORK_WR: begin
        if (!stat.out_busy) begin
          ctl.op    = DP_FORK;
          state_nxt = S_IDLE;
        end
      end
      S_EXIT: begin
        if (!stat.out_busy) begin
          ctl.op    = DP_EXIT;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_free) begin
          ctl.op    = DP_RD_SCAN;
          state_nxt = S_SCHED_HIT;
        end else if (stat.scan_at_start) begin
          if (!stat.out_busy) begin
            ctl.op         = DP_RESULT;
            ctl.res_status = ST_NO_RUN;
            state_nxt      = S_IDLE;
          end
        end else begin
          ctl.op = DP_SCAN_NEXT;
        end
      end
      S_SCHED_HIT: begin
        if (!stat.out_busy) begin
          ctl.op    = DP_SCHED_HIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/rrtt_dp.sv @@
// Datapath for the round-robin task table: task memory, running flags,
// count/current/id registers, scan pointer and result register. Depends on rrtt_pkg.
module rrtt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rrtt_pkg::dp_ctrl_t               ctl,
  output rrtt_pkg::dp_stat_t               stat,
  input  logic [rrtt_pkg::CMD_W-1:0]       in_cmd,
  input  logic [rrtt_pkg::REF_W-1:0]       in_name_ref,
  input  logic [rrtt_pkg::REF_W-1:0]       in_entry_ref,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rrtt_pkg::OUT_DATA_W-1:0]  out_data
);
  import rrtt_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REF_W-1:0] name_ref;
    logic [REF_W-1:0] entry_ref;
  } task_word_t;

  task_word_t mem_r [TABLE_DEPTH];
  task_word_t rdata_r;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [SLOT_W-1:0]      scan_r, scan_nxt;
  logic [ID_W-1:0]        next_id_r, next_id_nxt;
  logic [TABLE_DEPTH-1:0] flags_r, flags_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [REF_W-1:0]       name_in_r, entry_in_r;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_r;

  logic              wr_en, rd_en, res_load;
  logic [SLOT_W-1:0] wr_addr, rd_addr, cnt_slot, last_slot;
  task_word_t        wr_data;
  logic [SLOT_W-1:0]      res_slot;
  logic [ID_W-1:0]   res_id;
  logic [REF_W-1:0]  res_name, res_entry;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    slot_inc = (n == cnt) ? '0 : SLOT_W'(n);
  endfunction

  assign cnt_slot  = SLOT_W'(count_r);
  assign last_slot = SLOT_W'(count_r - CNT_W'(1));

  assign stat.cmd           = cmd_r;
  assign stat.full          = (count_r == CNT_W'(TABLE_DEPTH));
  assign stat.empty         = (count_r == '0);
  assign stat.cur_is_last   = (cur_r == last_slot);
  assign stat.scan_free     = !flags_r[scan_r];
  assign stat.scan_at_start = (scan_r == cur_r);
  assign stat.out_busy      = out_valid_r && !out_ready;

  always_comb begin
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    scan_nxt    = scan_r;
    next_id_nxt = next_id_r;
    flags_nxt   = flags_r;
    wr_en       = 1'b0;
    wr_addr     = cnt_slot;
    wr_data     = '{id: next_id_r, name_ref: name_in_r, entry_ref: entry_in_r};
    rd_en       = 1'b0;
    rd_addr     = cur_r;
    res_load    = 1'b0;
    res_slot    = '0;
    res_id      = '0;
    res_name    = '0;
    res_entry   = '0;
    unique case (ctl.op)
      DP_ADD, DP_FORK: begin
        wr_en = 1'b1;
        if (ctl.op == DP_FORK) begin
          wr_data.name_ref  = rdata_r.name_ref;
          wr_data.entry_ref = rdata_r.entry_ref;
        end
        flags_nxt[cnt_slot] = 1'b0;
        count_nxt   = count_r + CNT_W'(1);
        next_id_nxt = next_id_r + ID_W'(1);
        res_slot    = cnt_slot;
        res_id      = next_id_r;
        res_load    = 1'b1;
      end
      DP_RD_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      DP_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_slot;
      end
      DP_RD_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_r;
      end
      DP_EXIT: begin
        if (cur_r != last_slot) begin
          wr_en            = 1'b1;
          wr_addr          = cur_r;
          wr_data          = rdata_r;
          flags_nxt[cur_r] = flags_r[last_slot];
        end
        flags_nxt[last_slot] = 1'b0;
        count_nxt = count_r - CNT_W'(1);
        cur_nxt   = (CNT_W'(cur_r) >= count_nxt) ? '0 : cur_r;
        res_load  = 1'b1;
      end
      DP_SCAN_FIRST: scan_nxt = slot_inc(cur_r, count_r);
      DP_SCAN_NEXT:  scan_nxt = slot_inc(scan_r, count_r);
      DP_SCHED_HIT: begin
        flags_nxt[scan_r] = 1'b1;
        cur_nxt   = scan_r;
        res_slot  = scan_r;
        res_id    = rdata_r.id;
        res_name  = rdata_r.name_ref;
        res_entry = rdata_r.entry_ref;
        res_load  = 1'b1;
      end
      DP_FINISH: begin
        flags_nxt[cur_r] = 1'b0;
        res_load = 1'b1;
      end
      DP_RESULT: res_load = 1'b1;
      default: ;
    endcase
    out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_r       <= '0;
      scan_r      <= '0;
      next_id_r   <= ID_W'(1);
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      scan_r      <= scan_nxt;
      next_id_r   <= next_id_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == DP_LATCH) begin
      cmd_r      <= in_cmd;
      name_in_r  <= in_name_ref;
      entry_in_r <= in_entry_ref;
    end
    if (res_load) begin
      out_r.pad           <= '0;
      out_r.status        <= ctl.res_status;
      out_r.slot          <= SLOT_FIELD_W'(res_slot);
      out_r.task_id       <= res_id;
      out_r.run_name_ref  <= res_name;
      out_r.run_entry_ref <= res_entry;
      out_r.live_count    <= LIVE_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/round_robin_task_table.sv @@
// Top level of the round-robin task table: controller plus datapath.
// Depends on rrtt_pkg, rrtt_ctrl and rrtt_dp.
//
// Usage:
//   in_*  : one command per transfer; in_tuser carries the command code,
//           in_tdata the name and entry references used by add.
//   out_* : one result per command: status, slot, task id, the scheduled
//           task's references and the live task count.
// Commands are served one at a time; in_tready is high only while idle.
// Fork reads the current task, then writes the copy; exit reads the last
// task and moves it into the current slot unless the current slot is last;
// schedule steps through the slots after the current one until a ready task
// is found, or reports no ready task on return; the scan checks one slot per cycle.
// The next command is taken the cycle after the result is loaded.
// A stalled result waits in the output register; the block still takes
// the next command and holds its result until the register frees up.
// Reset empties the table, clears all running flags, sets the current
// slot to 0 and the next id to 1; the task memory is not cleared.
module round_robin_task_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rrtt_pkg::IN_DATA_W-1:0]  in_tdata,   // name_ref, entry_ref
  input  logic [rrtt_pkg::CMD_W-1:0]      in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, slot, task_id, run_name_ref, run_entry_ref, live_count, zero pad
  output logic [rrtt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import rrtt_pkg::*;

  dp_ctrl_t ctl;
  dp_stat_t stat;

  rrtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rrtt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .stat         (stat),
    .in_cmd       (in_tuser),
    .in_name_ref  (in_tdata[REF_W-1:0]),
    .in_entry_ref (in_tdata[2*REF_W-1:REF_W]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while another is in progress");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[LIVE_LSB +: LIVE_W] <= LIVE_W'(TABLE_DEPTH)))
    else $error("live count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[STATUS_W-1:0] == ST_FULL)
      |-> (out_tdata[LIVE_LSB +: LIVE_W] == LIVE_W'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[STATUS_W-1:0] == ST_EMPTY)
      |-> (out_tdata[LIVE_LSB +: LIVE_W] == '0))
    else $error("no tasks reported with live tasks");
`endif

endmodule

@@ dv/round_robin_task_table_tb.sv @@
// Self-checking testbench for round_robin_task_table: directed and random command streams
// are checked against an in-bench model of the task table.
// Depends on rrtt_pkg and the round_robin_task_table RTL.
module round_robin_task_table_tb;
  import rrtt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_SATURATE = 2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REF_W-1:0] name_ref;
    logic [REF_W-1:0] entry_ref;
  } task_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // name_ref, entry_ref
  logic [CMD_W-1:0]      in_tuser = '0;   // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status, slot, task_id, run_name_ref, run_entry_ref, live_count, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  round_robin_task_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  task_cmd_t pending_cmds[$];
  out_word_t expected_results[$];
  int        n_errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // table model
  logic [ID_W-1:0]  tbl_id    [TABLE_DEPTH] = '{default: '0};
  logic [REF_W-1:0] tbl_name  [TABLE_DEPTH] = '{default: '0};
  logic [REF_W-1:0] tbl_entry [TABLE_DEPTH] = '{default: '0};
  logic             tbl_busy  [TABLE_DEPTH] = '{default: 1'b0};
  int               n_tasks = 0;
  int               cur_slot = 0;
  logic [ID_W-1:0]  id_next = 16'd1;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic out_word_t serve_command(logic [CMD_W-1:0] cmd,
                                              logic [REF_W-1:0] nref,
                                              logic [REF_W-1:0] eref);
    out_word_t r;
    int cur, last, s, c;
    r = '0;
    cur = (n_tasks == 0) ? 0 : cur_slot % n_tasks;
    case (cmd)
      CMD_ADD, CMD_FORK: begin
        if (n_tasks >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_FORK && n_tasks == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = n_tasks;
          if (cmd == CMD_FORK) begin
            nref = tbl_name[cur];
            eref = tbl_entry[cur];
          end
          tbl_id[s] = id_next;
          id_next = id_next + 1'b1;
          tbl_name[s] = nref;
          tbl_entry[s] = eref;
          tbl_busy[s] = 1'b0;
          n_tasks = s + 1;
          r.slot = 4'(s);
          r.task_id = tbl_id[s];
        end
      end
      CMD_EXIT, CMD_SCHED, CMD_FINISH: begin
        if (n_tasks == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd == CMD_EXIT) begin
          last = n_tasks - 1;
          if (cur != last) begin
            tbl_id[cur] = tbl_id[last];
            tbl_name[cur] = tbl_name[last];
            tbl_entry[cur] = tbl_entry[last];
            tbl_busy[cur] = tbl_busy[last];
          end
          tbl_busy[last] = 1'b0;
          n_tasks = last;
          cur_slot = (cur >= n_tasks) ? 0 : cur;
        end else if (cmd == CMD_SCHED) begin
          c = cur;
          do begin
            c = (c + 1) % n_tasks;
          end while (tbl_busy[c] && c != cur);
          cur_slot = c;
          if (tbl_busy[c]) begin
            r.status = ST_NO_RUN;
          end else begin
            tbl_busy[c] = 1'b1;
            r.slot = 4'(c);
            r.task_id = tbl_id[c];
            r.run_name_ref = tbl_name[c];
            r.run_entry_ref = tbl_entry[c];
          end
        end else begin
          tbl_busy[cur] = 1'b0;
        end
      end
      default: ;
    endcase
    r.live_count = 5'(n_tasks);
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(int mode);
    int r;
    r = $urandom_range(99);
    if (r >= 97) return 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
    case (mode)
      MODE_GROW:
        return (r < 45) ? CMD_ADD : (r < 65) ? CMD_FORK : (r < 80) ? CMD_SCHED :
               (r < 90) ? CMD_FINISH : CMD_EXIT;
      MODE_SHRINK:
        return (r < 45) ? CMD_EXIT : (r < 65) ? CMD_SCHED : (r < 75) ? CMD_FINISH :
               (r < 85) ? CMD_ADD : CMD_FORK;
      default:
        return (r < 60) ? CMD_SCHED : (r < 72) ? CMD_ADD : (r < 80) ? CMD_FORK :
               (r < 88) ? CMD_FINISH : CMD_EXIT;
    endcase
  endfunction

  task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [REF_W-1:0] nref,
                          logic [REF_W-1:0] eref);
    task_cmd_t t;
    t.cmd = cmd;
    t.name_ref = nref;
    t.entry_ref = eref;
    pending_cmds.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(string what, logic [REF_W-1:0] want, logic [REF_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    task_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(serve_command(in_tuser, in_tdata[REF_W-1:0],
                                                 in_tdata[2*REF_W-1:REF_W]));
      if (in_tvalid && !in_tready) begin
        // hold current transfer
      end else if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.cmd;
        in_tdata <= {nxt.entry_ref, nxt.name_ref};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    out_word_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("slot", 32'(want.slot), 32'(got.slot));
          check_field("task_id", 32'(want.task_id), 32'(got.task_id));
          check_field("run_name_ref", want.run_name_ref, got.run_name_ref);
          check_field("run_entry_ref", want.run_entry_ref, got.run_entry_ref);
          check_field("live_count", 32'(want.live_count), 32'(got.live_count));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int mode;
    mode = MODE_GROW;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, reserved codes
    push_cmd(CMD_FORK, '0, '0);
    push_cmd(CMD_EXIT, '0, '0);
    push_cmd(CMD_SCHED, '0, '0);
    push_cmd(CMD_FINISH, '0, '0);
    push_cmd(CMD_RSVD5, '1, '1);
    push_cmd(CMD_RSVD6, '0, '1);
    push_cmd(CMD_RSVD7, '1, '0);
    // add three tasks, run every task, then nothing ready
    push_cmd(CMD_ADD, '0, '0);
    push_cmd(CMD_ADD, '1, '1);
    push_cmd(CMD_FORK, '1, '0);
    push_cmd(CMD_SCHED, '0, '0);
    push_cmd(CMD_SCHED, '0, '0);
    push_cmd(CMD_SCHED, '0, '0);
    push_cmd(CMD_SCHED, '0, '0);
    // finish running task, then finish on a ready one
    push_cmd(CMD_FINISH, '0, '0);
    push_cmd(CMD_FINISH, '0, '0);
    // exits down to empty
    push_cmd(CMD_EXIT, '0, '0);
    push_cmd(CMD_SCHED, '0, '0);
    push_cmd(CMD_EXIT, '0, '0);
    push_cmd(CMD_EXIT, '0, '0);
    push_cmd(CMD_EXIT, '0, '0);
    push_cmd(CMD_ADD, $urandom, $urandom);
    push_cmd(CMD_FORK, $urandom, $urandom);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int k = 0; k < 275; k++) begin
        if (k % 25 == 0) mode = $urandom_range(MODE_SATURATE, MODE_GROW);
        push_cmd(pick_cmd(mode), $urandom, $urandom);
      end
      wait_drained();
    end

    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ round_robin_task_table.f @@
sv/rrtt_pkg.sv
sv/rrtt_ctrl.sv
sv/rrtt_dp.sv
sv/round_robin_task_table.sv
dv/round_robin_task_table_tb.sv
